// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SMI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the clock cycle after the antecedent.
`define SMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/smi_pkg.sv =====
// ----------------------------------------------------------------------------
// Small matrix inverse package
// Shared widths, constants and types for the inverse pipeline.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits = 16;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int NumWidth = ProdWidth + 1;
  localparam int DetWidth = NumWidth + DataWidth + 2;
  localparam int DivNumWidth = NumWidth + 2 * FracBits;
  localparam int QuoWidth = DivNumWidth;
  localparam int NumLanes = 9;
  localparam int OrdWidth = 2;

  localparam logic [OrdWidth-1:0] OrderZero = 2'd0;
  localparam logic [OrdWidth-1:0] Order1 = 2'd1;
  localparam logic [OrdWidth-1:0] Order2 = 2'd2;
  localparam logic [OrdWidth-1:0] Order3 = 2'd3;

  typedef logic signed [DataWidth-1:0] elem_t;
  typedef logic signed [NumWidth-1:0] num_t;
  typedef logic signed [DetWidth-1:0] det_t;

  typedef struct packed {
    logic valid;
    logic singular;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/smi_cofactor.sv =====
// ----------------------------------------------------------------------------
// Cofactor unit
// Forms x*y - z*w exactly over two registered stages.
// ----------------------------------------------------------------------------
module smi_cofactor (
  input  logic                  clk,
  input  smi_pkg::elem_t        x,
  input  smi_pkg::elem_t        y,
  input  smi_pkg::elem_t        z,
  input  smi_pkg::elem_t        w,
  output smi_pkg::num_t         num
);

  logic signed [smi_pkg::ProdWidth-1:0] prod_a;
  logic signed [smi_pkg::ProdWidth-1:0] prod_b;

  always_ff @(posedge clk) begin
    prod_a <= smi_pkg::ProdWidth'(x) * smi_pkg::ProdWidth'(y);
    prod_b <= smi_pkg::ProdWidth'(z) * smi_pkg::ProdWidth'(w);
    num <= smi_pkg::num_t'(prod_a) - smi_pkg::num_t'(prod_b);
  end

endmodule

// ===== hw/rtl/smi_div_lane.sv =====
// ----------------------------------------------------------------------------
// Division lane
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module smi_div_lane (
  input  logic                 clk,
  input  smi_pkg::num_t        num,
  input  smi_pkg::det_t        det,
  output smi_pkg::elem_t       quo,
  output logic                 sat
);

  localparam int Steps = smi_pkg::QuoWidth;
  localparam int RemWidth = smi_pkg::DetWidth + 1;

  logic [smi_pkg::DivNumWidth-1:0] dividend [Steps+1];
  logic [RemWidth-1:0]             rem      [Steps+1];
  logic [smi_pkg::DetWidth-1:0]    divisor  [Steps+1];
  logic                            neg      [Steps+1];

  always_comb begin
    dividend[0] = {(num[smi_pkg::NumWidth-1] ? -num : num), {(2*smi_pkg::FracBits){1'b0}}};
    divisor[0] = det[smi_pkg::DetWidth-1] ? -det : det;
    rem[0] = '0;
    neg[0] = num[smi_pkg::NumWidth-1] ^ det[smi_pkg::DetWidth-1];
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemWidth-1:0] trial;
    logic                take;
    assign trial = {rem[s][RemWidth-2:0], dividend[s][smi_pkg::DivNumWidth-1]};
    assign take = trial >= {1'b0, divisor[s]};
    always_ff @(posedge clk) begin
      rem[s+1] <= take ? trial - {1'b0, divisor[s]} : trial;
      dividend[s+1] <= {dividend[s][smi_pkg::DivNumWidth-2:0], take};
      divisor[s+1] <= divisor[s];
      neg[s+1] <= neg[s];
    end
  end

  logic [smi_pkg::QuoWidth-1:0] mag;
  logic [smi_pkg::QuoWidth-1:0] limit;
  logic                         over;

  assign mag = dividend[Steps];
  assign limit = neg[Steps] ? smi_pkg::QuoWidth'(64'd1 << (smi_pkg::DataWidth - 1))
                            : smi_pkg::QuoWidth'((64'd1 << (smi_pkg::DataWidth - 1)) - 64'd1);
  assign over = mag > limit;

  always_ff @(posedge clk) begin
    sat <= over;
    quo <= neg[Steps] ? -smi_pkg::elem_t'(over ? limit : mag)
                      : smi_pkg::elem_t'(over ? limit : mag);
  end

endmodule

// ===== hw/rtl/small_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// Small matrix inverse
// Inverts a 1x1, 2x2 or 3x3 signed Q16.16 matrix by adjugate and determinant.
// An item is accepted when start is high and busy is low; busy is always low,
// so one matrix may enter every clock cycle. The result appears on r11..r33,
// singular and overflow for exactly one cycle, marked by done, after two
// cofactor stages, three determinant stages (partial products, lane
// products, order select), one stage per quotient bit of the nine divider
// lanes (97), one saturation stage and one output stage. Throughput is
// one item per cycle, set by the fully pipelined divider lanes. The
// receiver cannot stall the block.
// matrix_order is written with order_we and order_wdata; the user must do so
// only while idle, which the block does not enforce. Zero acts as order three.
// Reset sets the order to three and drops results in flight; none is invented.
// ----------------------------------------------------------------------------
module small_matrix_inverse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         order_we,
  input  logic [smi_pkg::OrdWidth-1:0] order_wdata,
  input  logic                         start,
  output logic                         busy,
  input  smi_pkg::elem_t               e11, e21, e31, e12, e22, e32, e13, e23, e33,
  output logic                         done,
  output smi_pkg::elem_t               r11, r21, r31, r12, r22, r32, r13, r23, r33,
  output logic                         singular,
  output logic                         overflow
);

  `include "assert_macros.svh"

  localparam int Lat = 4 + smi_pkg::QuoWidth + 1;
  localparam int SingStage = 5;

  logic [smi_pkg::OrdWidth-1:0] matrix_order;
  logic [smi_pkg::OrdWidth-1:0] ord_s1;
  logic [smi_pkg::OrdWidth-1:0] ord_s2;
  logic [smi_pkg::OrdWidth-1:0] ord_s3;
  logic [smi_pkg::OrdWidth-1:0] ord_s4;
  smi_pkg::elem_t a [smi_pkg::NumLanes];
  smi_pkg::elem_t ad [smi_pkg::NumLanes];
  smi_pkg::elem_t ad2 [smi_pkg::NumLanes];
  smi_pkg::elem_t e11_d3;
  smi_pkg::elem_t e11_d4;
  smi_pkg::num_t  cof [smi_pkg::NumLanes];
  smi_pkg::num_t  n_sel [smi_pkg::NumLanes];
  smi_pkg::num_t  n_reg [smi_pkg::NumLanes];
  smi_pkg::num_t  n_pipe [smi_pkg::NumLanes];
  smi_pkg::num_t  n_div [smi_pkg::NumLanes];
  smi_pkg::num_t  det2;
  smi_pkg::num_t  det2_d;
  smi_pkg::num_t  pp_lo [3];
  smi_pkg::num_t  pp_hi [3];
  smi_pkg::det_t  dprod [3];
  smi_pkg::det_t  det_sel;
  smi_pkg::det_t  det;
  smi_pkg::elem_t quo [smi_pkg::NumLanes];
  logic           sat [smi_pkg::NumLanes];
  smi_pkg::lane_ctl_t ctl [Lat+1];
  logic [smi_pkg::NumLanes-1:0] sat_vec;
  logic det_zero;

  function automatic logic [smi_pkg::OrdWidth-1:0] order_eff(
    input logic [smi_pkg::OrdWidth-1:0] o
  );
    order_eff = (o == smi_pkg::OrderZero) ? smi_pkg::Order3 : o;
  endfunction

  assign busy = 1'b0;
  assign a = '{e11, e21, e31, e12, e22, e32, e13, e23, e33};

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order <= smi_pkg::Order3;
    end else if (order_we) begin
      matrix_order <= order_wdata;
    end
  end

  smi_cofactor u_c0 (.clk, .x(a[4]), .y(a[8]), .z(a[7]), .w(a[5]), .num(cof[0]));
  smi_cofactor u_c1 (.clk, .x(a[7]), .y(a[2]), .z(a[1]), .w(a[8]), .num(cof[1]));
  smi_cofactor u_c2 (.clk, .x(a[1]), .y(a[5]), .z(a[4]), .w(a[2]), .num(cof[2]));
  smi_cofactor u_c3 (.clk, .x(a[6]), .y(a[5]), .z(a[3]), .w(a[8]), .num(cof[3]));
  smi_cofactor u_c4 (.clk, .x(a[0]), .y(a[8]), .z(a[6]), .w(a[2]), .num(cof[4]));
  smi_cofactor u_c5 (.clk, .x(a[3]), .y(a[2]), .z(a[0]), .w(a[5]), .num(cof[5]));
  smi_cofactor u_c6 (.clk, .x(a[3]), .y(a[7]), .z(a[6]), .w(a[4]), .num(cof[6]));
  smi_cofactor u_c7 (.clk, .x(a[6]), .y(a[1]), .z(a[0]), .w(a[7]), .num(cof[7]));
  smi_cofactor u_c8 (.clk, .x(a[0]), .y(a[4]), .z(a[3]), .w(a[1]), .num(cof[8]));

  always_ff @(posedge clk) begin
    ad <= a;
    ad2 <= ad;
    ord_s1 <= order_eff(matrix_order);
    ord_s2 <= ord_s1;
  end

  always_comb begin
    for (int i = 0; i < smi_pkg::NumLanes; i++) begin
      n_sel[i] = '0;
    end
    if (ord_s2 == smi_pkg::Order1) begin
      n_sel[0] = smi_pkg::num_t'(1);
    end else if (ord_s2 == smi_pkg::Order2) begin
      n_sel[0] = smi_pkg::num_t'(ad2[4]);
      n_sel[1] = -smi_pkg::num_t'(ad2[1]);
      n_sel[3] = -smi_pkg::num_t'(ad2[3]);
      n_sel[4] = smi_pkg::num_t'(ad2[0]);
    end else begin
      n_sel = cof;
    end
  end

  always_ff @(posedge clk) begin
    n_reg <= n_sel;
    ord_s3 <= ord_s2;
    det2 <= cof[8];
    e11_d3 <= ad2[0];
    for (int k = 0; k < 3; k++) begin
      pp_lo[k] <= smi_pkg::num_t'(ad2[3*k])
                * smi_pkg::num_t'($signed({1'b0, cof[k][smi_pkg::DataWidth-1:0]}));
      pp_hi[k] <= smi_pkg::num_t'(ad2[3*k])
                * smi_pkg::num_t'($signed(cof[k][smi_pkg::NumWidth-1:smi_pkg::DataWidth]));
    end
  end

  always_ff @(posedge clk) begin
    n_pipe <= n_reg;
    ord_s4 <= ord_s3;
    det2_d <= det2;
    e11_d4 <= e11_d3;
    for (int k = 0; k < 3; k++) begin
      dprod[k] <= (smi_pkg::det_t'(pp_hi[k]) <<< smi_pkg::DataWidth)
                + smi_pkg::det_t'(pp_lo[k]);
    end
  end

  always_comb begin
    case (ord_s4)
      smi_pkg::Order1: det_sel = smi_pkg::det_t'(e11_d4);
      smi_pkg::Order2: det_sel = smi_pkg::det_t'(det2_d);
      default:         det_sel = dprod[0] + dprod[1] + dprod[2];
    endcase
  end

  always_ff @(posedge clk) begin
    det <= det_sel;
    n_div <= n_pipe;
  end

  for (genvar l = 0; l < smi_pkg::NumLanes; l++) begin : g_lane
    smi_div_lane u_div (.clk, .num(n_div[l]), .det(det), .quo(quo[l]), .sat(sat[l]));
    assign sat_vec[l] = sat[l];
  end

  assign det_zero = (det == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= Lat; i++) begin
        ctl[i] <= '0;
      end
    end else begin
      ctl[0] <= '{valid: start && !busy, singular: 1'b0};
      for (int i = 1; i <= Lat; i++) begin
        if (i == SingStage) begin
          ctl[i] <= '{valid: ctl[i-1].valid, singular: det_zero};
        end else begin
          ctl[i] <= ctl[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[Lat].valid;
    end
  end

  always_ff @(posedge clk) begin
    singular <= ctl[Lat].singular;
    overflow <= !ctl[Lat].singular && (sat_vec != '0);
    r11 <= ctl[Lat].singular ? '0 : quo[0];
    r21 <= ctl[Lat].singular ? '0 : quo[1];
    r31 <= ctl[Lat].singular ? '0 : quo[2];
    r12 <= ctl[Lat].singular ? '0 : quo[3];
    r22 <= ctl[Lat].singular ? '0 : quo[4];
    r32 <= ctl[Lat].singular ? '0 : quo[5];
    r13 <= ctl[Lat].singular ? '0 : quo[6];
    r23 <= ctl[Lat].singular ? '0 : quo[7];
    r33 <= ctl[Lat].singular ? '0 : quo[8];
  end

  `SMI_ASSERT_NEXT(a_done_follows, ctl[Lat].valid, done, "done missing after pipeline")
  `SMI_ASSERT_IMP(a_sing_no_ovf, done && singular, !overflow, "overflow with singular")
  `SMI_ASSERT_IMP(a_sing_zero, done && singular, r11 == '0 && r22 == '0 && r33 == '0,
    "singular result not zero")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Small matrix inverse testbench
// Sends 1x1, 2x2 and 3x3 Q16.16 matrices in bursts and compares every
// inverse, singular flag and overflow flag with an exact wide-integer
// prediction. Identity, singular, extreme and saturating matrices are
// covered, followed by random well-conditioned and raw random matrices
// under each matrix order, order zero included.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LatencyCycles = 150;
  localparam int WatchdogLimit = 4000;

  typedef logic signed [255:0] wide_t;
  typedef logic [8:0][31:0] matrix_t;
  typedef struct packed {
    matrix_t elem;
    logic singular;
    logic overflow;
  } inverse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic order_we = 1'b0;
  logic [1:0] order_wdata = '0;
  logic start = 1'b0;
  logic busy;
  smi_pkg::elem_t e11 = '0, e21 = '0, e31 = '0, e12 = '0, e22 = '0, e32 = '0;
  smi_pkg::elem_t e13 = '0, e23 = '0, e33 = '0;
  logic done;
  smi_pkg::elem_t r11, r21, r31, r12, r22, r32, r13, r23, r33;
  logic singular;
  logic overflow;

  inverse_t expected_inverses[$];
  logic [1:0] model_order = smi_pkg::Order3;
  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 10;
  logic accepted_now;

  small_matrix_inverse i_dut (
    .clk, .rst, .order_we, .order_wdata, .start, .busy,
    .e11, .e21, .e31, .e12, .e22, .e32, .e13, .e23, .e33,
    .done, .r11, .r21, .r31, .r12, .r22, .r32, .r13, .r23, .r33,
    .singular, .overflow
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic wide_t cofactor_of(wide_t x, wide_t y, wide_t z, wide_t w);
    return x * y - z * w;
  endfunction

  function automatic logic [31:0] scaled_quotient(wide_t num, wide_t det, inout logic ovf);
    logic neg;
    logic [255:0] mag_num, mag_det, quo, limit, neg_quo;
    neg = (num < 0) != (det < 0);
    mag_num = (num < 0) ? -num : num;
    mag_det = (det < 0) ? -det : det;
    quo = (mag_num << (2 * smi_pkg::FracBits)) / mag_det;
    limit = neg ? 256'h8000_0000 : 256'h7fff_ffff;
    if (quo > limit) begin
      ovf = 1'b1;
      quo = limit;
    end
    neg_quo = -quo;
    return neg ? neg_quo[31:0] : quo[31:0];
  endfunction

  function automatic inverse_t invert_matrix(matrix_t m, logic [1:0] ord);
    wide_t a[9];
    wide_t n[9];
    wide_t det;
    inverse_t res;
    logic ovf;
    for (int i = 0; i < 9; i++) begin
      a[i] = wide_t'($signed(m[i]));
      n[i] = '0;
    end
    if (ord == smi_pkg::Order1) begin
      n[0] = 1;
      det = a[0];
    end else if (ord == smi_pkg::Order2) begin
      det = cofactor_of(a[0], a[4], a[3], a[1]);
      n[0] = a[4];
      n[1] = -a[1];
      n[3] = -a[3];
      n[4] = a[0];
    end else begin
      n[0] = cofactor_of(a[4], a[8], a[7], a[5]);
      n[1] = cofactor_of(a[7], a[2], a[1], a[8]);
      n[2] = cofactor_of(a[1], a[5], a[4], a[2]);
      n[3] = cofactor_of(a[6], a[5], a[3], a[8]);
      n[4] = cofactor_of(a[0], a[8], a[6], a[2]);
      n[5] = cofactor_of(a[3], a[2], a[0], a[5]);
      n[6] = cofactor_of(a[3], a[7], a[6], a[4]);
      n[7] = cofactor_of(a[6], a[1], a[0], a[7]);
      n[8] = cofactor_of(a[0], a[4], a[3], a[1]);
      det = a[0] * n[0] + a[3] * n[1] + a[6] * n[2];
    end
    res = '0;
    ovf = 1'b0;
    if (det == 0) begin
      res.singular = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) res.elem[i] = scaled_quotient(n[i], det, ovf);
      res.overflow = ovf;
    end
    return res;
  endfunction

  task automatic send_matrix(matrix_t m);
    int gap;
    start <= 1'b1;
    {e33, e23, e13, e32, e22, e12, e31, e21, e11} <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_inverses.push_back(invert_matrix(m, model_order));
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic write_order(logic [1:0] ord);
    start <= 1'b0;
    @(posedge clk);
    while (expected_inverses.size() != 0) @(posedge clk);
    order_we <= 1'b1;
    order_wdata <= ord;
    @(posedge clk);
    model_order = ord;
    order_we <= 1'b0;
  endtask

  function automatic logic [31:0] q16(int value);
    return 32'(value) << smi_pkg::FracBits;
  endfunction

  function automatic matrix_t diagonal_matrix(logic [31:0] d);
    matrix_t m;
    m = '0;
    m[0] = d;
    m[4] = d;
    m[8] = d;
    return m;
  endfunction

  function automatic matrix_t random_matrix(logic [1:0] ord);
    matrix_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 6) m[i] = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      else if (kind < 8) m[i] = 32'($signed($urandom_range(0, 32'h0000_0800)) - 32'sh400);
      else m[i] = $urandom;
    end
    if ($urandom_range(0, 11) == 0) begin
      if (ord == smi_pkg::Order1) m[0] = '0;
      else begin
        m[1] = m[0];
        m[4] = m[3];
        m[7] = m[6];
      end
    end
    return m;
  endfunction

  task automatic test_directed_order3();
    matrix_t m;
    send_matrix(diagonal_matrix(q16(1)));
    send_matrix(diagonal_matrix(q16(-2)));
    send_matrix('0);
    send_matrix({9{32'h7fff_ffff}});
    send_matrix(diagonal_matrix(32'h8000_0000));
    send_matrix(diagonal_matrix(32'h7fff_ffff));
    send_matrix(diagonal_matrix(32'h0000_0001));
    send_matrix(diagonal_matrix(32'hffff_ffff));
    m = diagonal_matrix(q16(1));
    m[3] = q16(5);
    m[7] = 32'h8000_0000;
    send_matrix(m);
    m = '1;
    m[0] = '0;
    m[4] = 32'h8000_0000;
    send_matrix(m);
  endtask

  task automatic test_directed_small_orders();
    matrix_t m;
    write_order(smi_pkg::Order2);
    m = {9{32'h5555_aaaa}};
    m[0] = q16(2);
    m[4] = q16(3);
    m[1] = q16(1);
    m[3] = q16(-1);
    send_matrix(m);
    send_matrix({9{32'h8000_0000}});
    m[1] = 32'h7fff_ffff;
    m[3] = 32'h8000_0000;
    send_matrix(m);
    send_matrix(diagonal_matrix(32'h0000_0002));
    write_order(smi_pkg::Order1);
    send_matrix({9{32'haaaa_5555}} & ~matrix_t'(32'hffff_ffff) | matrix_t'(q16(4)));
    send_matrix('0);
    send_matrix(matrix_t'(32'h8000_0000));
    send_matrix(matrix_t'(32'h7fff_ffff));
    send_matrix(matrix_t'(32'h0000_0001));
    send_matrix(matrix_t'(32'hffff_ffff));
    write_order(smi_pkg::OrderZero);
    send_matrix(diagonal_matrix(q16(4)));
  endtask

  task automatic test_random_items(logic [1:0] ord, int count);
    write_order(ord);
    repeat (count) send_matrix(random_matrix(ord));
  endtask

  assign accepted_now = start && !busy;

  always @(posedge clk) begin
    inverse_t want;
    matrix_t got;
    if (!rst && done) begin
      got = {r33, r23, r13, r32, r22, r12, r31, r21, r11};
      if (expected_inverses.size() == 0) begin
        $display("%0t: result with no matrix pending: %h", $realtime, got);
        error_count++;
      end else begin
        want = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.elem[i]) begin
            $display("%0t: element %0d expected %h actual %h", $realtime, i,
                     want.elem[i], got[i]);
            error_count++;
          end
        end
        if (singular !== want.singular) begin
          $display("%0t: singular expected %b actual %b", $realtime, want.singular, singular);
          error_count++;
        end
        if (overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $realtime, want.overflow, overflow);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || accepted_now || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_order3();
    test_directed_small_orders();
    test_random_items(smi_pkg::Order3, 400);
    test_random_items(smi_pkg::Order2, 200);
    test_random_items(smi_pkg::Order1, 150);
    test_random_items(smi_pkg::OrderZero, 100);
    test_random_items(smi_pkg::Order3, 100);
    start <= 1'b0;
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
